>>> hw/rtl/lpcs_pkg.sv
`timescale 1ns / 1ps
package lpcs_pkg;
  localparam int MAX_GROUPS_DEF    = 16;
  localparam int MAX_HEIGHTS_DEF   = 32;
  localparam int MAX_TRANSECTS_DEF = 64;

  localparam int LOGW  = 24;
  localparam int SCW   = 48;
  localparam int CNTW  = 16;
  localparam int WTW   = 17;
  localparam int CATW  = 5;

  localparam logic [1:0] OP_TAB   = 2'd0;
  localparam logic [1:0] OP_TRAN  = 2'd1;
  localparam logic [1:0] OP_PIXEL = 2'd2;

  localparam logic signed [SCW-1:0] SCORE_MAX = {1'b0, {(SCW-1){1'b1}}};
  localparam logic signed [SCW-1:0] SCORE_MIN = {1'b1, {(SCW-1){1'b0}}};
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ACC, ST_TRAN, ST_EXP, ST_DRAW, ST_OUT
  } state_t;

  // Q1.16 table of 2^(-i/16)
  function automatic logic [16:0] exp2tab(input logic [3:0] i);
    logic [16:0] v;
    case (i)
      4'd0: v = 17'd65536;  4'd1: v = 17'd62757;
      4'd2: v = 17'd60097;  4'd3: v = 17'd57549;
      4'd4: v = 17'd55109;  4'd5: v = 17'd52773;
      4'd6: v = 17'd50535;  4'd7: v = 17'd48393;
      4'd8: v = 17'd46341;  4'd9: v = 17'd44376;
      4'd10: v = 17'd42495; 4'd11: v = 17'd40693;
      4'd12: v = 17'd38968; 4'd13: v = 17'd37316;
      4'd14: v = 17'd35734; 4'd15: v = 17'd34219;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  // saturate a 49-bit sum to the 48-bit signed score range
  function automatic logic signed [SCW-1:0] sat48(input logic signed [SCW:0] v);
    logic signed [SCW-1:0] r;
    if (v[SCW] != v[SCW-1]) r = v[SCW] ? SCORE_MIN : SCORE_MAX;
    else r = v[SCW-1:0];
    return r;
  endfunction
endpackage

>>> hw/rtl/lpcs_if.sv
`timescale 1ns / 1ps
interface lpcs_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic [3:0]        group_index;
  logic [4:0]        height_index;
  logic [5:0]        transect_index;
  logic signed [23:0] log_pi;
  logic signed [23:0] log_one_minus_pi;
  logic signed [23:0] log_theta;
  logic [15:0]       returns;
  logic [15:0]       misses;
  logic              last_of_pixel;
  logic [15:0]       uniform;
  modport source (output valid, opcode, group_index, height_index, transect_index,
                  log_pi, log_one_minus_pi, log_theta, returns, misses,
                  last_of_pixel, uniform, input ready);
  modport sink (input valid, opcode, group_index, height_index, transect_index,
                log_pi, log_one_minus_pi, log_theta, returns, misses,
                last_of_pixel, uniform, output ready);
endinterface

interface lpcs_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] category;
  modport source (output valid, category, input ready);
  modport sink (input valid, category, output ready);
endinterface

interface lpcs_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

>>> hw/rtl/lpcs_mac.sv
`timescale 1ns / 1ps
// Shared 17x25 multiplier with registered product; used for counts*log and
// for the scaled exponent.
module lpcs_mac (
  input  logic                      clk,
  input  logic [16:0]               a,
  input  logic signed [lpcs_pkg::LOGW:0] b,
  output logic signed [42:0]        p_r
);
  import lpcs_pkg::*;
  logic signed [42:0] p_nxt;
  assign p_nxt = 43'(signed'({1'b0, a}) * b);
  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end
endmodule

>>> hw/rtl/lda_pixel_category_sampler.sv
`timescale 1ns / 1ps
// Channel | Dir | Payload
// in_     | in  | opcode, indices, log values, counts, last_of_pixel, uniform
// out_    | out | category
// cfg_    | in  | groups_in_use (5 bits)
// Table writes complete when accepted. A pixel item is accepted and then processed for all MAX_GROUPS
// groups (read, data, two multiplies and write back per group through one shared multiplier);
// a last item then runs the transect add and the exponentials for each group in use, and the draw
// over at most the groups in use, then holds the result until out_ready.
// Reset (sync, active low) clears control state and scores; tables are not cleared.
// in_ready is low while an item is in work or a result waits on out_ready.
module lda_pixel_category_sampler #(
  parameter int MAX_GROUPS    = lpcs_pkg::MAX_GROUPS_DEF,
  parameter int MAX_HEIGHTS   = lpcs_pkg::MAX_HEIGHTS_DEF,
  parameter int MAX_TRANSECTS = lpcs_pkg::MAX_TRANSECTS_DEF
) (
  input logic clk,
  input logic rst_n,
  lpcs_in_if.sink    in_ch,
  lpcs_out_if.source out_ch,
  lpcs_cfg_if.sink   cfg_ch
);
  import lpcs_pkg::*;
  localparam int GW  = $clog2(MAX_GROUPS);
  localparam int HW  = (MAX_HEIGHTS > 1) ? $clog2(MAX_HEIGHTS) : 1;
  localparam int TW  = (MAX_TRANSECTS > 1) ? $clog2(MAX_TRANSECTS) : 1;
  localparam int GTW = $clog2(MAX_GROUPS + 1);
  localparam int TD  = MAX_GROUPS * MAX_HEIGHTS;
  localparam int WD  = MAX_TRANSECTS * MAX_GROUPS;
  localparam int TAW = $clog2(TD);
  localparam int WAW = $clog2(WD);
  localparam int TOTW = WTW + GW + 1;

  // memories
  logic signed [LOGW-1:0] ret_mem [TD];
  logic signed [LOGW-1:0] mis_mem [TD];
  logic signed [LOGW-1:0] tw_mem  [WD];
  logic signed [LOGW-1:0] ret_q_r, mis_q_r, tw_q_r;
  logic [WTW-1:0] wt_mem [MAX_GROUPS];
  logic [WTW-1:0] wt_q_r;
  logic signed [SCW-1:0] score_r [MAX_GROUPS];

  state_t state_r, state_nxt;
  logic [4:0] giu_r;
  logic [GTW-1:0] g_eff;
  logic [GW-1:0] k_r;
  logic [2:0] ph_r;
  logic [HW-1:0] hgt_r;
  logic hgt_ok_r, tr_ok_r;
  logic [TW-1:0] tr_r;
  logic [15:0] ret_cnt_r, mis_cnt_r, uni_r;
  logic last_r;
  logic signed [SCW-1:0] mx_r, acc_r;
  logic [TOTW-1:0] total_r, cum_r;
  logic [TOTW+16-1:0] thresh_r;
  logic [CATW-1:0] cat_r;
  logic found_r;

  logic [16:0] mul_a;
  logic signed [LOGW:0] mul_b;
  logic signed [42:0] prod_r;

  lpcs_mac u_mac (.clk(clk), .a(mul_a), .b(mul_b), .p_r(prod_r));

  assign g_eff = (32'(giu_r) > MAX_GROUPS) ? GTW'(MAX_GROUPS) : GTW'(giu_r);
  logic k_last;
  assign k_last = ({1'b0, k_r} == (GW+1)'(g_eff - 1'b1));
  logic k_all;
  assign k_all = ({1'b0, k_r} == (GW+1)'(MAX_GROUPS - 1));

  logic in_fire, out_fire;
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = (state_r == ST_OUT);
  assign out_ch.category = cat_r;
  assign out_fire     = out_ch.valid && out_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // memory addresses
  logic [TAW-1:0] wr_taddr, rd_taddr;
  logic [WAW-1:0] wr_waddr, rd_waddr;
  assign wr_taddr = TAW'(in_ch.group_index) * TAW'(MAX_HEIGHTS) + TAW'(in_ch.height_index);
  assign rd_taddr = TAW'(k_r) * TAW'(MAX_HEIGHTS) + TAW'(hgt_r);
  assign wr_waddr = WAW'(in_ch.transect_index) * WAW'(MAX_GROUPS) + WAW'(in_ch.group_index);
  assign rd_waddr = WAW'(tr_r) * WAW'(MAX_GROUPS) + WAW'(k_r);
  logic tab_wr, tw_wr;
  assign tab_wr = in_fire && in_ch.opcode == OP_TAB &&
                  32'(in_ch.group_index) < MAX_GROUPS && 32'(in_ch.height_index) < MAX_HEIGHTS;
  assign tw_wr  = in_fire && in_ch.opcode == OP_TRAN &&
                  32'(in_ch.group_index) < MAX_GROUPS && 32'(in_ch.transect_index) < MAX_TRANSECTS;

  always_ff @(posedge clk) begin
    if (tab_wr) begin
      ret_mem[wr_taddr] <= in_ch.log_pi;
      mis_mem[wr_taddr] <= in_ch.log_one_minus_pi;
    end
    if (tw_wr) tw_mem[wr_waddr] <= in_ch.log_theta;
    ret_q_r <= ret_mem[rd_taddr];
    mis_q_r <= mis_mem[rd_taddr];
    tw_q_r  <= tw_mem[rd_waddr];
    wt_q_r  <= wt_mem[k_r];
  end

  // exponent: y = (-d)*LOG2E >> 16, with d clamped to Q8.16 range
  logic signed [SCW-1:0] dcur;
  logic [LOGW-1:0] negd;
  assign dcur = score_r[k_r] - mx_r;
  assign negd = (dcur < -48'sd8388608) ? 24'd8388608 : 24'(-dcur);
  logic [26:0] y;
  assign y = 27'(prod_r >>> 16);
  logic [WTW-1:0] wexp;
  assign wexp = (y[26:16] >= 11'd17) ? '0 : WTW'(exp2tab(y[15:12]) >> y[20:16]);

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_ACC: begin
        mul_a = (ph_r == 3'd2) ? {1'b0, ret_cnt_r} : {1'b0, mis_cnt_r};
        mul_b = (ph_r == 3'd2) ? (LOGW+1)'(ret_q_r) : (LOGW+1)'(mis_q_r);
      end
      ST_EXP: begin
        mul_a = LOG2E_Q16;
        mul_b = (LOGW+1)'({1'b0, negd});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_fire && in_ch.opcode == OP_PIXEL) state_nxt = ST_ACC;
      ST_ACC:  if (ph_r == 3'd4 && k_all)
                 state_nxt = last_r ? ((g_eff == '0) ? ST_OUT : ST_TRAN) : ST_IDLE;
      ST_TRAN: if (ph_r == 3'd1 && k_last) state_nxt = ST_EXP;
      ST_EXP:  if (ph_r == 3'd1 && k_last) state_nxt = ST_DRAW;
      ST_DRAW: if (ph_r == 3'd1 && (k_last || found_r)) state_nxt = ST_OUT;
      ST_OUT:  if (out_fire) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer datapath
  logic signed [SCW:0] sum49;
  always_comb begin
    case (state_r)
      ST_ACC:  sum49 = (SCW+1)'(acc_r) + (SCW+1)'(prod_r);
      default: sum49 = (SCW+1)'(score_r[k_r]) + (SCW+1)'(tw_q_r);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      giu_r   <= 5'd16;
      k_r     <= '0;
      ph_r    <= '0;
      for (int i = 0; i < MAX_GROUPS; i++) score_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid) giu_r <= cfg_ch.data;
      case (state_r)
        ST_IDLE: begin
          k_r <= '0;
          ph_r <= '0;
          if (in_fire) begin
            hgt_r     <= HW'(in_ch.height_index);
            hgt_ok_r  <= 32'(in_ch.height_index) < MAX_HEIGHTS;
            tr_r      <= TW'(in_ch.transect_index);
            tr_ok_r   <= 32'(in_ch.transect_index) < MAX_TRANSECTS;
            ret_cnt_r <= in_ch.returns;
            mis_cnt_r <= in_ch.misses;
            uni_r     <= in_ch.uniform;
            last_r    <= in_ch.last_of_pixel;
            cat_r     <= '0;
          end
        end
        // ph0 read, ph1 data, ph2 mul r, ph3 mul m + acc, ph4 add m
        ST_ACC: begin
          case (ph_r)
            3'd3: acc_r <= sat48(sum49);
            3'd2: acc_r <= score_r[k_r];
            default: ;
          endcase
          if (ph_r == 3'd4) begin
            if (hgt_ok_r) score_r[k_r] <= sat48(sum49);
            ph_r <= '0;
            k_r  <= k_all ? '0 : k_r + 1'b1;
          end else ph_r <= ph_r + 1'b1;
        end
        // add transect weight, track maximum
        ST_TRAN: begin
          if (ph_r == 3'd1) begin
            logic signed [SCW-1:0] s;
            s = tr_ok_r ? sat48(sum49) : score_r[k_r];
            score_r[k_r] <= s;
            if (k_r == '0 || s > mx_r) mx_r <= s;
            ph_r <= '0;
            k_r <= k_last ? '0 : k_r + 1'b1;
            total_r <= '0;
          end else ph_r <= ph_r + 1'b1;
        end
        // ph0 multiply, ph1 table+shift
        ST_EXP: begin
          if (ph_r == 3'd1) begin
            wt_mem[k_r] <= wexp;
            total_r <= total_r + TOTW'(wexp);
            ph_r <= '0;
            k_r <= k_last ? '0 : k_r + 1'b1;
            cum_r <= '0;
            found_r <= 1'b0;
            cat_r <= '0;
          end else ph_r <= ph_r + 1'b1;
        end
        // ph0 read weight, ph1 compare; total is final here
        ST_DRAW: begin
          thresh_r <= (TOTW+16)'(uni_r) * (TOTW+16)'(total_r);
          if (ph_r == 3'd1) begin
            logic [TOTW-1:0] c;
            c = cum_r + TOTW'(wt_q_r);
            cum_r <= c;
            if (!found_r && thresh_r < {c, 16'd0}) begin
              found_r <= 1'b1;
              cat_r <= CATW'(k_r) + 1'b1;
            end
            ph_r <= '0;
            k_r <= k_r + 1'b1;
          end else ph_r <= ph_r + 1'b1;
          if (state_nxt == ST_OUT)
            for (int i = 0; i < MAX_GROUPS; i++) score_r[i] <= '0;
        end
        ST_OUT: begin
          k_r <= '0;
          if (g_eff == '0) begin
            cat_r <= '0;
            for (int i = 0; i < MAX_GROUPS; i++) score_r[i] <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // assertions
  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ch.ready) else $error("ready while busy");
  a_cat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ({1'b0, out_ch.category} <= 6'(g_eff))) else $error("category range");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> out_ch.valid && $stable(out_ch.category))
    else $error("result dropped");
endmodule
